>>> sv/assert_macros.svh
// Assertion macros for the Bezier sampler RTL.
// Included by the top level; expects aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its trigger.
`define BZS_ASSERT_SAME(label, trig, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cons)) \
        else $error("bezier sampler check failed");

// Check a consequent in the cycle after its trigger.
`define BZS_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error("bezier sampler check failed");

`endif

>>> sv/bzs_pkg.sv
// Shared types and constants for the cubic Bezier sampler.
// No dependencies.
`timescale 1ns / 1ps
package bzs_pkg;
    localparam int CFG_W   = 7;          // num_points register width
    localparam int T_W     = 17;         // t and u, 16 fraction bits plus 1.0
    localparam int W_W     = 33;         // weights, 32 fraction bits plus 1.0
    localparam int DIV_STEPS = 17;       // quotient bits of 65536 / d
    localparam int CNT_W   = 5;
    localparam logic [CFG_W-1:0] NUM_POINTS_RST = 7'd16;
    localparam logic [T_W-1:0]   T_ONE = 17'h10000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN
    } bzs_state_t;

    // Per-point control passed from the sequencer into the pipeline
    typedef struct packed {
        logic vld;
        logic last;
    } bzs_tag_t;
endpackage

>>> sv/bzs_tgen.sv
// Request sequencer: latches control points, divides 65536 by the step
// count, then steps the curve parameter t once per point. Uses bzs_pkg.
`timescale 1ns / 1ps
module bzs_tgen #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16,
    parameter int IDX_W = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [8*COORD_BITS-1:0]     s_tdata,
    input  logic [bzs_pkg::CFG_W-1:0]   num_points,
    input  logic                        en,
    output bzs_pkg::bzs_tag_t           issue_tag,
    output logic [IDX_W-1:0]            issue_idx,
    output logic [bzs_pkg::T_W-1:0]     issue_t,
    output logic [8*COORD_BITS-1:0]     issue_pts
);
    import bzs_pkg::*;

    bzs_state_t state_reg, state_next;
    logic [IDX_W-1:0]        d_reg, d_next;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        div_rem_reg;
    logic [IDX_W-1:0]        acc_rem_reg;
    logic [T_W-1:0]          q_reg;
    logic [T_W-1:0]          t_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [8*COORD_BITS-1:0] pts_reg;
    logic [IDX_W:0]          trial;
    logic [IDX_W:0]          step_sum;
    logic                    step_wrap;
    logic                    accept;

    // Clamp the configured count and form d = n - 1
    always_comb begin
        if (num_points < CFG_W'(2)) begin
            d_next = IDX_W'(1);
        end else if (int'(num_points) > MAX_POINTS) begin
            d_next = IDX_W'(MAX_POINTS - 1);
        end else begin
            d_next = IDX_W'(num_points - CFG_W'(1));
        end
    end

    // Restoring divider step and remainder stepping
    assign trial     = {div_rem_reg, (cnt_reg == '0)};
    assign step_sum  = {1'b0, acc_rem_reg} + {1'b0, div_rem_reg};
    assign step_wrap = step_sum >= {1'b0, d_reg};
    assign accept    = s_tvalid && s_tready;

    // Next state and outputs
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        issue_tag  = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                issue_tag.vld  = 1'b1;
                issue_tag.last = (idx_reg == d_reg);
                if (en && issue_tag.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign issue_idx = idx_reg;
    assign issue_t   = t_reg;
    assign issue_pts = pts_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hold request data, run the divider, advance t
    always_ff @(posedge aclk) begin
        if (accept) begin
            pts_reg     <= s_tdata;
            d_reg       <= d_next;
            div_rem_reg <= '0;
            q_reg       <= '0;
            cnt_reg     <= '0;
        end else if (state_reg == ST_DIV) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (trial >= {1'b0, d_reg}) begin
                div_rem_reg <= IDX_W'(trial - {1'b0, d_reg});
                q_reg       <= {q_reg[T_W-2:0], 1'b1};
            end else begin
                div_rem_reg <= trial[IDX_W-1:0];
                q_reg       <= {q_reg[T_W-2:0], 1'b0};
            end
            t_reg       <= '0;
            idx_reg     <= '0;
            acc_rem_reg <= d_reg >> 1;
        end else if (state_reg == ST_RUN && en) begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (step_wrap) begin
                acc_rem_reg <= IDX_W'(step_sum - {1'b0, d_reg});
                t_reg       <= t_reg + q_reg + T_W'(1);
            end else begin
                acc_rem_reg <= step_sum[IDX_W-1:0];
                t_reg       <= t_reg + q_reg;
            end
        end
    end
endmodule

>>> sv/bzs_datapath.sv
// Six-stage Bernstein evaluation pipeline: weights, products, sum,
// rounding and saturation, ending in the output register. Uses bzs_pkg.
`timescale 1ns / 1ps
module bzs_datapath #(
    parameter int COORD_BITS = 16,
    parameter int IDX_W = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bzs_pkg::bzs_tag_t           in_tag,
    input  logic [IDX_W-1:0]            in_idx,
    input  logic [bzs_pkg::T_W-1:0]     in_t,
    input  logic [8*COORD_BITS-1:0]     in_pts,
    output logic                        en,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [COORD_BITS-1:0]       out_x,
    output logic [COORD_BITS-1:0]       out_y,
    output logic [IDX_W-1:0]            out_idx,
    output logic                        out_last
);
    import bzs_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int PR_W = W_W + 1 + C;       // signed weight * coordinate
    localparam int SM_W = PR_W + 2;          // sum of four products
    localparam int RD_W = SM_W - 32;         // after dropping fraction bits
    localparam int NS   = 5;                 // stages before the output
    localparam int WF_W = 3*T_W + 2;         // raw cubic term

    bzs_tag_t        tag_reg [NS];
    logic [IDX_W-1:0] idx_reg [NS];
    logic [8*C-1:0]  pts_reg [3];

    logic [T_W-1:0]      u_next;
    logic [T_W-1:0]      t_a_reg, u_a_reg;
    logic [2*T_W-1:0]    uu_a_reg, tt_a_reg;
    logic [W_W-1:0]      w0_b_reg, w1_b_reg, w2_b_reg;
    logic [WF_W-1:0]     w0_full, w1_full, w2_full;
    logic [W_W-1:0]      w0_c_reg, w1_c_reg, w2_c_reg, w3_c_reg;
    logic signed [PR_W-1:0] prod_reg [8];
    logic signed [SM_W-1:0] sx_reg, sy_reg;
    logic signed [RD_W-1:0] rx, ry;
    logic [W_W-1:0]      wsel [4];

    // Whole pipeline advances unless the output holds an untaken result
    assign en = !out_valid || out_ready;

    // Stage A: t, u and their squares
    assign u_next = T_ONE - in_t;

    // Stage B: raw Bernstein terms with 16 bits dropped
    assign w0_full = WF_W'(uu_a_reg) * WF_W'(u_a_reg);
    assign w1_full = WF_W'(3) * WF_W'(uu_a_reg) * WF_W'(t_a_reg);
    assign w2_full = WF_W'(3) * WF_W'(tt_a_reg) * WF_W'(u_a_reg);

    assign wsel[0] = w0_c_reg;
    assign wsel[1] = w1_c_reg;
    assign wsel[2] = w2_c_reg;
    assign wsel[3] = w3_c_reg;

    // Stage F input: arithmetic shift keeps floor rounding
    assign rx = RD_W'(sx_reg >>> 32);
    assign ry = RD_W'(sy_reg >>> 32);

    function automatic logic [C-1:0] sat(input logic signed [RD_W-1:0] v);
        logic signed [RD_W-1:0] hi;
        logic signed [RD_W-1:0] lo;
        hi = RD_W'((64'sd1 <<< (C - 1)) - 64'sd1);
        lo = -hi - RD_W'(1);
        if (v > hi) begin
            sat = hi[C-1:0];
        end else if (v < lo) begin
            sat = lo[C-1:0];
        end else begin
            sat = v[C-1:0];
        end
    endfunction

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NS; s++) begin
                tag_reg[s] <= '0;
            end
            out_valid <= 1'b0;
        end else if (en) begin
            tag_reg[0] <= in_tag;
            for (int s = 1; s < NS; s++) begin
                tag_reg[s] <= tag_reg[s-1];
            end
            out_valid <= tag_reg[NS-1].vld;
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            idx_reg[0] <= in_idx;
            for (int s = 1; s < NS; s++) begin
                idx_reg[s] <= idx_reg[s-1];
            end
            // A
            t_a_reg    <= in_t;
            u_a_reg    <= u_next;
            uu_a_reg   <= u_next * u_next;
            tt_a_reg   <= in_t * in_t;
            pts_reg[0] <= in_pts;
            // B
            w0_b_reg   <= w0_full[W_W+15:16];
            w1_b_reg   <= w1_full[W_W+15:16];
            w2_b_reg   <= w2_full[W_W+15:16];
            pts_reg[1] <= pts_reg[0];
            // C
            w0_c_reg   <= w0_b_reg;
            w1_c_reg   <= w1_b_reg;
            w2_c_reg   <= w2_b_reg;
            w3_c_reg   <= (W_W'(1) << 32) - w0_b_reg - w1_b_reg - w2_b_reg;
            pts_reg[2] <= pts_reg[1];
            // D: fields alternate x, y per control point
            for (int k = 0; k < 8; k++) begin
                prod_reg[k] <= PR_W'($signed({1'b0, wsel[k/2]}))
                               * PR_W'($signed(pts_reg[2][k*C +: C]));
            end
            // E: sum with the rounding half
            sx_reg <= SM_W'(prod_reg[0]) + SM_W'(prod_reg[2]) + SM_W'(prod_reg[4])
                      + SM_W'(prod_reg[6]) + (SM_W'(1) <<< 31);
            sy_reg <= SM_W'(prod_reg[1]) + SM_W'(prod_reg[3]) + SM_W'(prod_reg[5])
                      + SM_W'(prod_reg[7]) + (SM_W'(1) <<< 31);
            // F: output register
            out_x    <= sat(rx);
            out_y    <= sat(ry);
            out_idx  <= idx_reg[NS-1];
            out_last <= tag_reg[NS-1].last;
        end
    end
endmodule

>>> sv/cubic_bezier_sampler_core.sv
// Cubic Bezier sampler: one request of four control points P0..P3 yields
// num_points curve points at t = i/(n-1), rounded and saturated Q12.4,
// with tlast on the final point. A request occupies the sequencer for
// its accept, a 17-bit bit-serial divide of 65536 by n-1, then one point
// per cycle, unless the output stalls, into a six-stage pipeline. Output
// stalls freeze the whole pipeline. Uses bzs_pkg, bzs_tgen, bzs_datapath.
`timescale 1ns / 1ps
module cubic_bezier_sampler_core #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y from bit 0 up
    input  logic [8*COORD_BITS-1:0]         s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // curve_x, curve_y, point_index from bit 0 up, zero padded
    output logic [((2*COORD_BITS+$clog2(MAX_POINTS)+7)/8)*8-1:0] m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bzs_pkg::CFG_W-1:0]       cfg_data
);
    import bzs_pkg::*;
    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int OUT_W = ((2*COORD_BITS + IDX_W + 7) / 8) * 8;

    logic [CFG_W-1:0]        num_points_reg;
    logic                    en;
    bzs_tag_t                issue_tag;
    logic [IDX_W-1:0]        issue_idx;
    logic [T_W-1:0]          issue_t;
    logic [8*COORD_BITS-1:0] issue_pts;
    logic [COORD_BITS-1:0]   out_x, out_y;
    logic [IDX_W-1:0]        out_idx;

    // Point count register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_points_reg <= NUM_POINTS_RST;
        end else if (cfg_valid) begin
            num_points_reg <= cfg_data;
        end
    end

    bzs_tgen #(
        .MAX_POINTS(MAX_POINTS),
        .COORD_BITS(COORD_BITS),
        .IDX_W(IDX_W)
    ) u_tgen (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .num_points(num_points_reg),
        .en(en),
        .issue_tag(issue_tag),
        .issue_idx(issue_idx),
        .issue_t(issue_t),
        .issue_pts(issue_pts)
    );

    bzs_datapath #(
        .COORD_BITS(COORD_BITS),
        .IDX_W(IDX_W)
    ) u_datapath (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_tag(issue_tag),
        .in_idx(issue_idx),
        .in_t(issue_t),
        .in_pts(issue_pts),
        .en(en),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_x(out_x),
        .out_y(out_y),
        .out_idx(out_idx),
        .out_last(m_tlast)
    );

    assign m_tdata = OUT_W'({out_idx, out_y, out_x});

    // An accepted request makes the sequencer busy
    `BZS_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)
    // The final point issued returns the sequencer to idle
    `BZS_ASSERT_NEXT(a_idle_after_last, issue_tag.vld && issue_tag.last && en, s_tready)
    // Nothing enters the pipeline while a request can be taken
    `BZS_ASSERT_SAME(a_no_issue_idle, s_tready, !issue_tag.vld)
endmodule
